// ----- design/ftpp_pkg.sv -----
// Shared types and codes for the file-transfer packet parser.
// Holds the transfer phase enum, packet type, tag and status codes, and the
// structs passed between the parse stage, the name check and the top level.
package ftpp_pkg;

   // Transfer phase: START expected, transfer open, error, complete.
   typedef enum logic [1:0] {
      PH_WAIT,
      PH_OPEN,
      PH_ERR,
      PH_DONE
   } phase_type;

   // Packet type codes as carried in the first byte of a packet.
   localparam logic [1:0] PT_NONE  = 2'd0;
   localparam logic [1:0] PT_DATA  = 2'd1;
   localparam logic [1:0] PT_START = 2'd2;
   localparam logic [1:0] PT_END   = 2'd3;

   // Control packet tags.
   localparam logic [7:0] TAG_SIZE = 8'd0;
   localparam logic [7:0] TAG_NAME = 8'd1;

   // Per-packet status codes.
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_BAD_TYPE      = 3'd1;
   localparam logic [2:0] ST_BAD_TAG       = 3'd2;
   localparam logic [2:0] ST_BAD_SEQ       = 3'd3;
   localparam logic [2:0] ST_SIZE_MISMATCH = 3'd4;
   localparam logic [2:0] ST_NAME_MISMATCH = 3'd5;
   localparam logic [2:0] ST_BAD_LENGTH    = 3'd6;
   localparam logic [2:0] ST_COMPLETE      = 3'd7;

   // Result of the parse stage for one item, before the name check.
   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        packet_done;
      logic [2:0]  status;
      logic [63:0] xfer_size;
      logic        transfer_error;
      logic        end_check;   // END passed all checks but the name bytes
      logic        len_eq;      // END name length matched the START length
      logic        cmp_en;      // this byte is compared with the stored name
      logic        pkt_begin;   // first byte of a packet
      logic [7:0]  cmp_byte;
   } rec_type;

   // Final result item.
   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        packet_done;
      logic [2:0]  status;
      logic [63:0] xfer_size;
      logic        transfer_error;
   } rsp_type;

   // Name memory access issued with each accepted item.
   typedef struct packed {
      logic       wr_en;
      logic [7:0] idx;
      logic [7:0] wdata;
   } name_cmd_type;

endpackage

// ----- design/file_transfer_packet_parser.sv -----
// Top level of the file-transfer packet parser: input handshake, the stage
// that waits for the name memory read, and the output register.
// Depends on ftpp_pkg, ftpp_parse and ftpp_name_check.
//
// Use: packet bytes enter on the req_ channel, one byte per item, with
// req_tlast on the last byte of each link frame. Every accepted byte gives
// exactly one item on the rsp_ channel: a file data byte (rsp_tuser high)
// for DATA payload, and on the frame's last byte rsp_tlast with the packet
// status. The decoded START size and an error flag (sticky, except that a
// name mismatch flags only the END item) ride on every item. An accepted
// item passes the middle stage, which also takes the name memory read, and
// then the output register, which takes the name compare, before it is
// offered on rsp_tvalid. Throughput is one item per cycle while rsp_tready
// is high; the middle stage covers the memory read, so no item waits on it.
// When rsp_tready is low the output register holds its item and the middle
// stage still takes one more byte; req_tready drops only when both are full.
// Reset clears the transfer to waiting for START, with size zero. The name
// memory is not cleared; entries are only compared after START wrote them.
module file_transfer_packet_parser import ftpp_pkg::*; #(
   parameter int NAME_DEPTH     = 256,
   parameter int SIZE_BYTES_MAX = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] payload_byte, [10:8] status,
                                    // [74:11] xfer_size, [75] transfer_error
   output logic        rsp_tuser,   // payload_valid
   output logic        rsp_tlast    // packet_done
);

   logic         accept, advance, move;
   rec_type      rec, rec_ff, rec_in;
   name_cmd_type cmd;
   rsp_type      rsp, rsp_ff;
   logic         s2_valid_ff, s2_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s2_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign move       = s2_valid_ff && advance;

   ftpp_parse #(
      .NAME_DEPTH     (NAME_DEPTH),
      .SIZE_BYTES_MAX (SIZE_BYTES_MAX)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .frame_end (req_tlast),
      .rec       (rec),
      .cmd       (cmd)
   );

   ftpp_name_check #(
      .NAME_DEPTH (NAME_DEPTH)
   ) u_name_check (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cmd    (cmd),
      .move   (move),
      .rec    (rec_ff),
      .rsp    (rsp)
   );

   // Middle stage loads whenever it is free or its item moves on.
   always_comb begin
      s2_valid_in  = req_tready ? accept : s2_valid_ff;
      rec_in       = accept ? rec : rec_ff;
      rsp_valid_in = advance ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (advance) begin
         rsp_ff <= rsp;
      end
   end

   // Output packing.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.payload_valid;
   assign rsp_tlast  = rsp_ff.packet_done;
   assign rsp_tdata  = {4'd0, rsp_ff.transfer_error, rsp_ff.xfer_size,
                        rsp_ff.status, rsp_ff.payload_byte};

endmodule

// ----- design/ftpp_parse.sv -----
// Parse stage of the file-transfer packet parser: per-transfer and per-packet
// registers, byte decode, and the name memory command for each item.
// Depends on ftpp_pkg.
module ftpp_parse import ftpp_pkg::*; #(
   parameter int NAME_DEPTH     = 256,
   parameter int SIZE_BYTES_MAX = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   data_byte,
   input  logic         frame_end,
   output rec_type      rec,
   output name_cmd_type cmd
);

   phase_type   phase_ff, phase_in;
   logic [16:0] pos_ff, pos_in;
   logic [1:0]  ptype_ff, ptype_in;
   logic [7:0]  seq_ff, seq_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] flen_ff, flen_in;
   logic [63:0] ssize_ff, ssize_in;
   logic [7:0]  snlen_ff, snlen_in;
   logic        leq_ff, leq_in;

   logic        skip;
   logic [2:0]  skip_code;
   logic        pv, done, end_chk, cmp, wr, begin_pkt, complete;
   logic [2:0]  st;
   logic [16:0] lim_tag_name, lim_name_len, lim_name_end, lim_end;
   logic [16:0] name_off;
   logic [16:0] data_off;
   logic        skipping;

   // Byte decode and next state.
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      ptype_in  = ptype_ff;
      seq_in    = seq_ff;
      acc_in    = acc_ff;
      flen_in   = flen_ff;
      ssize_in  = ssize_ff;
      snlen_in  = snlen_ff;
      leq_in    = leq_ff;
      skip      = 1'b0;
      skip_code = ST_OK;
      pv        = 1'b0;
      done      = 1'b0;
      end_chk   = 1'b0;
      cmp       = 1'b0;
      wr        = 1'b0;
      begin_pkt = 1'b0;
      complete  = 1'b0;
      st        = ST_OK;
      skipping  = (ptype_ff == PT_NONE) && (pos_ff != 17'd0);

      // Field boundaries of a control packet.
      lim_tag_name = 17'd3 + {9'd0, flen_ff[7:0]};
      lim_name_len = 17'd4 + {9'd0, flen_ff[7:0]};
      lim_name_end = 17'd5 + {9'd0, flen_ff[7:0]} + {9'd0, flen_ff[15:8]};
      name_off     = pos_ff - 17'd5 - {9'd0, flen_ff[7:0]};
      data_off     = pos_ff - 17'd4;

      if (!skipping) begin
         if (pos_ff == 17'd0) begin
            begin_pkt = 1'b1;
            leq_in    = 1'b1;
            if ((data_byte == {6'd0, PT_START} && phase_ff == PH_WAIT) ||
                ((data_byte == {6'd0, PT_DATA} || data_byte == {6'd0, PT_END}) &&
                 phase_ff == PH_OPEN)) begin
               ptype_in = data_byte[1:0];
            end else begin
               skip      = 1'b1;
               skip_code = ST_BAD_TYPE;
            end
         end else if (ptype_ff == PT_DATA) begin
            // DATA: sequence, 16-bit length, payload.
            if (pos_ff == 17'd1) begin
               if (data_byte != seq_ff) begin
                  skip      = 1'b1;
                  skip_code = ST_BAD_SEQ;
               end
            end else if (pos_ff == 17'd2) begin
               flen_in = {data_byte, 8'd0};
            end else if (pos_ff == 17'd3) begin
               flen_in = {flen_ff[15:8], data_byte};
            end else if (data_off < {1'b0, flen_ff}) begin
               pv = 1'b1;
            end else begin
               skip      = 1'b1;
               skip_code = ST_BAD_LENGTH;
            end
         end else begin
            // START or END: size TLV, then name TLV.
            if (pos_ff == 17'd1) begin
               if (data_byte != TAG_SIZE) begin
                  skip      = 1'b1;
                  skip_code = ST_BAD_TAG;
               end
            end else if (pos_ff == 17'd2) begin
               if (data_byte > 8'(SIZE_BYTES_MAX)) begin
                  skip      = 1'b1;
                  skip_code = ST_BAD_LENGTH;
               end else begin
                  flen_in = {8'd0, data_byte};
                  acc_in  = 64'd0;
               end
            end else if (pos_ff < lim_tag_name) begin
               acc_in = {acc_ff[55:0], data_byte};
            end else if (pos_ff == lim_tag_name) begin
               if (data_byte != TAG_NAME) begin
                  skip      = 1'b1;
                  skip_code = ST_BAD_TAG;
               end
            end else if (pos_ff == lim_name_len) begin
               if (ptype_ff == PT_START && {9'd0, data_byte} > 17'(NAME_DEPTH)) begin
                  skip      = 1'b1;
                  skip_code = ST_BAD_LENGTH;
               end else begin
                  if (ptype_ff == PT_START) begin
                     snlen_in = data_byte;
                  end else begin
                     leq_in = (data_byte == snlen_ff);
                  end
                  flen_in = {data_byte, flen_ff[7:0]};
               end
            end else if (pos_ff < lim_name_end) begin
               if (ptype_ff == PT_START) begin
                  wr = (name_off < 17'(NAME_DEPTH));
               end else begin
                  cmp = leq_ff && (name_off < {9'd0, snlen_ff}) &&
                        (name_off < 17'(NAME_DEPTH));
               end
            end else begin
               skip      = 1'b1;
               skip_code = ST_BAD_LENGTH;
            end
         end
      end

      // Error: skip the rest of the packet, keep the code for frame end.
      if (skip) begin
         phase_in = PH_ERR;
         ptype_in = PT_NONE;
         flen_in  = {13'd0, skip_code};
         pos_in   = 17'd1;
      end

      // Completeness uses the lengths as updated by this byte.
      lim_end = 17'd4 + {9'd0, flen_in[7:0]} + {9'd0, flen_in[15:8]};
      if (ptype_in == PT_DATA) begin
         complete = (pos_ff >= 17'd3) && (pos_ff == 17'd3 + {1'b0, flen_in});
      end else begin
         complete = (pos_ff == lim_end);
      end

      // Frame end closes the packet and reports its status.
      if (frame_end) begin
         done = 1'b1;
         if (ptype_in == PT_NONE) begin
            st = flen_in[2:0];
         end else if (!complete) begin
            st       = ST_BAD_LENGTH;
            phase_in = PH_ERR;
         end else if (ptype_in == PT_START) begin
            ssize_in = acc_in;
            seq_in   = 8'd0;
            phase_in = PH_OPEN;
         end else if (ptype_in == PT_DATA) begin
            seq_in = seq_ff + 8'd1;
         end else if (acc_in != ssize_ff) begin
            st       = ST_SIZE_MISMATCH;
            phase_in = PH_ERR;
         end else begin
            // Name bytes are settled one stage later.
            end_chk  = 1'b1;
            phase_in = PH_DONE;
         end
         pos_in   = 17'd0;
         ptype_in = PT_NONE;
      end else if (ptype_in != PT_NONE) begin
         pos_in = pos_ff + 17'd1;
      end
   end

   // Record and memory command for this item.
   always_comb begin
      rec.payload_valid  = pv;
      rec.payload_byte   = pv ? data_byte : 8'd0;
      rec.packet_done    = done;
      rec.status         = st;
      rec.xfer_size      = ssize_in;
      rec.transfer_error = (phase_in == PH_ERR);
      rec.end_check      = end_chk;
      rec.len_eq         = leq_in;
      rec.cmp_en         = cmp;
      rec.pkt_begin      = begin_pkt;
      rec.cmp_byte       = data_byte;
      cmd.wr_en          = wr;
      cmd.idx            = name_off[7:0];
      cmd.wdata          = data_byte;
   end

   // State registers advance once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         pos_ff   <= 17'd0;
         ptype_ff <= PT_NONE;
         seq_ff   <= 8'd0;
         acc_ff   <= 64'd0;
         flen_ff  <= 16'd0;
         ssize_ff <= 64'd0;
         snlen_ff <= 8'd0;
         leq_ff   <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         ptype_ff <= ptype_in;
         seq_ff   <= seq_in;
         acc_ff   <= acc_in;
         flen_ff  <= flen_in;
         ssize_ff <= ssize_in;
         snlen_ff <= snlen_in;
         leq_ff   <= leq_in;
      end
   end

endmodule

// ----- design/ftpp_name_check.sv -----
// Name store of the file-transfer packet parser and the END name compare.
// Holds the synchronous name memory and the per-packet mismatch flag.
// Depends on ftpp_pkg.
module ftpp_name_check import ftpp_pkg::*; #(
   parameter int NAME_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  name_cmd_type cmd,
   input  logic         move,
   input  rec_type      rec,
   output rsp_type      rsp
);

   localparam int AW = $clog2(NAME_DEPTH);

   logic [7:0]      name_mem [NAME_DEPTH];
   logic [7:0]      rdata_ff;
   logic [AW+7:0]   idx_ext;
   logic [AW-1:0]   addr;
   logic            neq_ff, neq_in;
   logic            hit, neq_now, name_ok;

   assign idx_ext = {{AW{1'b0}}, cmd.idx};
   assign addr    = idx_ext[AW-1:0];

   // Name bytes written at START; every item reads its entry for the next stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (cmd.wr_en) begin
            name_mem[addr] <= cmd.wdata;
         end
         rdata_ff <= name_mem[addr];
      end
   end

   // Compare of the registered entry with the END name byte.
   always_comb begin
      hit     = rec.cmp_en && (rdata_ff != rec.cmp_byte);
      neq_now = (rec.pkt_begin ? 1'b0 : neq_ff) | hit;
      neq_in  = neq_now;
      name_ok = rec.len_eq && !neq_now;
   end

   // Final fields of the item.
   always_comb begin
      rsp.payload_valid  = rec.payload_valid;
      rsp.payload_byte   = rec.payload_byte;
      rsp.packet_done    = rec.packet_done;
      rsp.xfer_size      = rec.xfer_size;
      rsp.status         = rec.end_check ?
                           (name_ok ? ST_COMPLETE : ST_NAME_MISMATCH) : rec.status;
      rsp.transfer_error = rec.transfer_error || (rec.end_check && !name_ok);
   end

   // Mismatch flag follows the items as they leave this stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         neq_ff <= 1'b0;
      end else if (move) begin
         neq_ff <= neq_in;
      end
   end

endmodule
